// ===== src/kltr_pkg.sv =====
// ----------------------------------------------------------------------------
// kltr_pkg
// Shared types and constants for the keypad layout to HID report core.
// ----------------------------------------------------------------------------
package kltr_pkg;

    localparam int KEY_W        = 8;
    localparam int MAX_BUTTONS  = 8;
    localparam int MAX_SLOTS    = 6;
    localparam int LAYOUT_COUNT = 8;
    localparam int LAYOUT_W     = 3;
    localparam int RANK_W       = 3;
    localparam int COUNT_W      = 3;
    localparam int CFG_ADDR_W   = 4;
    localparam int CFG_DATA_W   = MAX_BUTTONS * KEY_W;

    // one button lane after lookup and ranking
    typedef struct packed {
        logic              hit;
        logic [RANK_W-1:0] rank;
        logic [KEY_W-1:0]  code;
    } lane_t;

endpackage

// ===== src/kltr_lane.sv =====
// ----------------------------------------------------------------------------
// kltr_lane
// One button lane: ranks the button among lower pressed buttons and
// registers its keycode and slot claim.
// ----------------------------------------------------------------------------
module kltr_lane import kltr_pkg::*; #(
    parameter int LANE  = 0,
    parameter int SLOTS = 6
) (
    input  logic                   aclk,
    input  logic                   load,
    input  logic [MAX_BUTTONS-1:0] pressed,
    input  logic [KEY_W-1:0]       code_in,
    output lane_t                  lane_reg
);

    localparam logic [RANK_W-1:0] SLOT_LIMIT = RANK_W'(SLOTS);

    lane_t             lane_next;
    logic [RANK_W-1:0] rank;

    always_comb begin
        rank = '0;
        for (int j = 0; j < LANE; j++) begin
            rank = rank + RANK_W'(pressed[j]);
        end
        lane_next.rank = rank;
        lane_next.code = code_in;
        lane_next.hit  = pressed[LANE] && (rank < SLOT_LIMIT);
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            lane_reg <= lane_next;
        end
    end

endmodule

// ===== src/kltr_merge.sv =====
// ----------------------------------------------------------------------------
// kltr_merge
// Merges the lane results into report slots and a key count, and holds
// the output register.
// ----------------------------------------------------------------------------
module kltr_merge import kltr_pkg::*; #(
    parameter int NB = 8
) (
    input  logic                aclk,
    input  logic                load,
    input  lane_t               lanes [NB],
    input  logic                sys_mode,
    input  logic [LAYOUT_W-1:0] layout,
    output logic [KEY_W-1:0]    slot_reg [MAX_SLOTS],
    output logic [COUNT_W-1:0]  keys_held_reg,
    output logic                mode_lamp_reg,
    output logic [LAYOUT_W-1:0] active_layout_reg
);

    logic [KEY_W-1:0]   slot_next [MAX_SLOTS];
    logic [COUNT_W-1:0] keys_held_next;

    always_comb begin
        keys_held_next = '0;
        for (int s = 0; s < MAX_SLOTS; s++) begin
            slot_next[s] = '0;
        end
        if (!sys_mode) begin
            for (int l = 0; l < NB; l++) begin
                keys_held_next = keys_held_next + COUNT_W'(lanes[l].hit);
                for (int s = 0; s < MAX_SLOTS; s++) begin
                    if (lanes[l].hit && (lanes[l].rank == RANK_W'(s))) begin
                        slot_next[s] = slot_next[s] | lanes[l].code;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            slot_reg          <= slot_next;
            keys_held_reg     <= keys_held_next;
            mode_lamp_reg     <= sys_mode;
            active_layout_reg <= layout;
        end
    end

endmodule

// ===== src/keypad_layout_to_hid_report_core.sv =====
// ----------------------------------------------------------------------------
// keypad_layout_to_hid_report_core
// Turns button polls into six-key HID boot keyboard reports through
// software-loaded keycode layouts, with a layout selection mode.
// ----------------------------------------------------------------------------
//  channel  | ports                      | contents
//  input    | s_tvalid/s_tready/s_tdata  | tdata: buttons; tuser: system switch
//  output   | m_tvalid/m_tready/m_tdata  | tdata: slots, count, layout; tuser: lamp
//  config   | cfg_wr_en/cfg_addr/cfg_wdata | layout words 0..7
//
// one poll per cycle unless m_tready stalls; stages: lane register, then output register
// a layout selection shows in its own report and sets the keycodes of the next accepted poll
// m_tready low with a report held stalls both stages; s_tready follows the lane stage
// synchronous active-low reset clears valids, layout select and layout words
// ----------------------------------------------------------------------------
module keypad_layout_to_hid_report_core import kltr_pkg::*; #(
    parameter int NUM_BUTTONS  = 8,
    parameter int REPORT_SLOTS = 6
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,   // [7:0] buttons_pressed
    input  logic                  s_tuser,   // [0] system_switch
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [55:0]           m_tdata,   // [47:0] slot_zero..five_key,
                                             // [50:48] keys_held,
                                             // [53:51] active_layout, [55:54] 0
    output logic                  m_tuser,   // [0] mode_lamp
    input  logic                  cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    logic [CFG_DATA_W-1:0] layout_word_reg [LAYOUT_COUNT];
    logic [LAYOUT_W-1:0]   layout_reg, layout_next;
    logic                  s1_valid_reg, s1_valid_next;
    logic                  m_valid_reg, m_valid_next;
    logic                  s1_sys_reg;
    logic [LAYOUT_W-1:0]   s1_layout_reg;
    logic                  in_accept, s1_advance, out_free;
    logic [MAX_BUTTONS-1:0] pressed;
    logic [CFG_DATA_W-1:0] cur_word;
    lane_t                 lanes [NUM_BUTTONS];
    logic [KEY_W-1:0]      slot_reg [MAX_SLOTS];
    logic [COUNT_W-1:0]    keys_held_reg;
    logic                  mode_lamp_reg;
    logic [LAYOUT_W-1:0]   active_layout_reg;

    assign out_free   = !m_valid_reg || m_tready;
    assign s1_advance = s1_valid_reg && out_free;
    assign s_tready   = !s1_valid_reg || out_free;
    assign in_accept  = s_tvalid && s_tready;
    assign pressed    = s_tdata;
    assign cur_word   = layout_word_reg[layout_reg];

    always_comb begin
        layout_next = layout_reg;
        if (s_tuser) begin
            for (int b = NUM_BUTTONS - 1; b >= 0; b--) begin
                if (pressed[b]) begin
                    layout_next = LAYOUT_W'(b);
                end
            end
        end
        s1_valid_next = in_accept || (s1_valid_reg && !out_free);
        m_valid_next  = s1_advance || (m_valid_reg && !m_tready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            layout_reg   <= '0;
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            for (int k = 0; k < LAYOUT_COUNT; k++) begin
                layout_word_reg[k] <= '0;
            end
        end else begin
            s1_valid_reg <= s1_valid_next;
            m_valid_reg  <= m_valid_next;
            if (in_accept) begin
                layout_reg <= layout_next;
            end
            if (cfg_wr_en && (cfg_addr < CFG_ADDR_W'(LAYOUT_COUNT))) begin
                layout_word_reg[cfg_addr[LAYOUT_W-1:0]] <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_accept) begin
            s1_sys_reg    <= s_tuser;
            s1_layout_reg <= layout_next;
        end
    end

    for (genvar l = 0; l < NUM_BUTTONS; l++) begin : g_lane
        kltr_lane #(
            .LANE  (l),
            .SLOTS (REPORT_SLOTS)
        ) u_lane (
            .aclk     (aclk),
            .load     (in_accept),
            .pressed  (pressed),
            .code_in  (cur_word[l*KEY_W +: KEY_W]),
            .lane_reg (lanes[l])
        );
    end

    kltr_merge #(
        .NB (NUM_BUTTONS)
    ) u_merge (
        .aclk              (aclk),
        .load              (s1_advance),
        .lanes             (lanes),
        .sys_mode          (s1_sys_reg),
        .layout            (s1_layout_reg),
        .slot_reg          (slot_reg),
        .keys_held_reg     (keys_held_reg),
        .mode_lamp_reg     (mode_lamp_reg),
        .active_layout_reg (active_layout_reg)
    );

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = mode_lamp_reg;
    assign m_tdata  = {2'b00, active_layout_reg, keys_held_reg,
                       slot_reg[5], slot_reg[4], slot_reg[3],
                       slot_reg[2], slot_reg[1], slot_reg[0]};

`ifndef SYNTHESIS
    a_count_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (keys_held_reg <= COUNT_W'(REPORT_SLOTS)))
        else $error("key count exceeds slot count");

    a_system_release: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> (m_tdata[50:0] == '0))
        else $error("system mode report is not all released");

    a_layout_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (aresetn && in_accept && !s_tuser) |=> (layout_reg == $past(layout_reg)))
        else $error("layout changed in normal mode");
`endif

endmodule

// ===== dv/keypad_layout_to_hid_report_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keypad_layout_to_hid_report_core_tb
// Drives button polls and layout loads into the HID report core and checks
// every report against a typed row or a cycle-free predictor of layout selection
// and six-slot key packing, under varied source idling and sink back-pressure.
// ----------------------------------------------------------------------------
module keypad_layout_to_hid_report_core_tb;
    import kltr_pkg::*;

    localparam int NUM_BUTTONS     = 8;
    localparam int REPORT_SLOTS    = 6;
    localparam int RESET_ROWS      = 6;
    localparam int DIRECTED_ROWS   = 25;
    localparam int PHASES          = 8;
    localparam int ITEMS_PER_PHASE = 225;
    localparam int SETTLE_CYCLES   = 4;
    localparam int HOLD_CYCLES     = 300;
    localparam int QUIET_LIMIT     = 3000;

    typedef struct packed {
        logic [MAX_SLOTS-1:0][KEY_W-1:0] slot_key;
        logic [COUNT_W-1:0]              keys_held;
        logic                            mode_lamp;
        logic [LAYOUT_W-1:0]             active_layout;
    } hid_report_t;

    // typed rows carry the full report; slots are zero there
    typedef struct packed {
        logic [7:0]          buttons;
        logic                sys;
        bit                  typed;
        logic [COUNT_W-1:0]  held;
        logic                lamp;
        logic [LAYOUT_W-1:0] layout;
    } poll_row_t;

    typedef enum {LOAD_DIRECTED, LOAD_ZERO, LOAD_ONES, LOAD_RANDOM} layout_load_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [7:0]            s_tdata;   // [7:0] buttons_pressed
    logic                  s_tuser;   // [0] system_switch
    logic                  m_tvalid;
    logic                  m_tready;
    logic [55:0]           m_tdata;   // [47:0] slots, [50:48] keys_held, [53:51] layout
    logic                  m_tuser;   // [0] mode_lamp
    logic                  cfg_wr_en;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    logic [CFG_DATA_W-1:0] layout_word [LAYOUT_COUNT];
    logic [LAYOUT_W-1:0]   sel_layout;
    hid_report_t           pending_reports [$];
    hid_report_t           seen_report;
    hid_report_t           due_report;

    int src_idle_pct;
    int sink_stall_pct;
    int hold_asks = 0;
    int mismatch_count = 0;
    int polls_sent;
    int select_polls;
    int reports_checked = 0;
    int layout_loads;
    int quiet_cycles = 0;

    string slot_name [MAX_SLOTS] = '{"slot_zero_key", "slot_one_key", "slot_two_key",
                                     "slot_three_key", "slot_four_key", "slot_five_key"};

    layout_load_t phase_load [PHASES] = '{LOAD_RANDOM, LOAD_ONES, LOAD_RANDOM, LOAD_ZERO,
                                          LOAD_RANDOM, LOAD_DIRECTED, LOAD_RANDOM,
                                          LOAD_RANDOM};

    poll_row_t directed_rows [DIRECTED_ROWS] = '{
        '{8'hFF, 1'b0, 1'b1, 3'd6, 1'b0, 3'd0},
        '{8'h00, 1'b0, 1'b1, 3'd0, 1'b0, 3'd0},
        '{8'h00, 1'b1, 1'b1, 3'd0, 1'b1, 3'd0},
        '{8'h80, 1'b1, 1'b1, 3'd0, 1'b1, 3'd7},
        '{8'h00, 1'b0, 1'b1, 3'd0, 1'b0, 3'd7},
        '{8'hFF, 1'b1, 1'b1, 3'd0, 1'b1, 3'd0},
        '{8'h01, 1'b0, 1'b0, 3'd0, 1'b0, 3'd0},
        '{8'h80, 1'b0, 1'b0, 3'd0, 1'b0, 3'd0},
        '{8'hFF, 1'b0, 1'b0, 3'd0, 1'b0, 3'd0},
        '{8'hC0, 1'b0, 1'b0, 3'd0, 1'b0, 3'd0},
        '{8'h3F, 1'b0, 1'b0, 3'd0, 1'b0, 3'd0},
        '{8'h7F, 1'b0, 1'b0, 3'd0, 1'b0, 3'd0},
        '{8'h20, 1'b1, 1'b0, 3'd0, 1'b0, 3'd0},
        '{8'h08, 1'b0, 1'b0, 3'd0, 1'b0, 3'd0},
        '{8'hFF, 1'b0, 1'b0, 3'd0, 1'b0, 3'd0},
        '{8'h40, 1'b1, 1'b0, 3'd0, 1'b0, 3'd0},
        '{8'h55, 1'b0, 1'b0, 3'd0, 1'b0, 3'd0},
        '{8'h80, 1'b1, 1'b0, 3'd0, 1'b0, 3'd0},
        '{8'hAA, 1'b0, 1'b0, 3'd0, 1'b0, 3'd0},
        '{8'h00, 1'b1, 1'b0, 3'd0, 1'b0, 3'd0},
        '{8'hFF, 1'b0, 1'b0, 3'd0, 1'b0, 3'd0},
        '{8'h02, 1'b1, 1'b0, 3'd0, 1'b0, 3'd0},
        '{8'h0C, 1'b1, 1'b0, 3'd0, 1'b0, 3'd0},
        '{8'h18, 1'b1, 1'b0, 3'd0, 1'b0, 3'd0},
        '{8'hF0, 1'b0, 1'b0, 3'd0, 1'b0, 3'd0}
    };

    keypad_layout_to_hid_report_core #(
        .NUM_BUTTONS (NUM_BUTTONS),
        .REPORT_SLOTS(REPORT_SLOTS)
    ) u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .cfg_wr_en(cfg_wr_en),
        .cfg_addr (cfg_addr),
        .cfg_wdata(cfg_wdata)
    );

    always begin
        aclk = 1'b0;
        #1;
        aclk = 1'b1;
        #1;
    end

    // layout selection and six-slot packing for one poll
    function automatic hid_report_t predict_report(input logic [7:0] buttons,
                                                   input logic sys);
        hid_report_t rpt;
        int          fill;
        rpt  = '0;
        fill = 0;
        if (sys) begin
            // lowest pressed button wins
            for (int b = NUM_BUTTONS - 1; b >= 0; b--) begin
                if (buttons[b]) begin
                    sel_layout = b[LAYOUT_W-1:0];
                end
            end
        end else begin
            for (int b = 0; b < NUM_BUTTONS; b++) begin
                if (buttons[b] && fill < REPORT_SLOTS) begin
                    rpt.slot_key[fill] = layout_word[sel_layout][KEY_W*b +: KEY_W];
                    fill++;
                end
            end
        end
        rpt.keys_held     = fill[COUNT_W-1:0];
        rpt.mode_lamp     = sys;
        rpt.active_layout = sel_layout;
        return rpt;
    endfunction

    task automatic send_poll(input logic [7:0] buttons, input logic sys, input bit typed,
                             input hid_report_t typed_report);
        hid_report_t rpt;
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= buttons;
        s_tuser  <= sys;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        rpt = predict_report(buttons, sys);
        pending_reports.push_back(typed ? typed_report : rpt);
        polls_sent++;
        if (sys) select_polls++;
        @(negedge aclk);
    endtask

    task automatic cfg_write(input logic [CFG_ADDR_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] word);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= word;
        if (idx < LAYOUT_COUNT) layout_word[idx[LAYOUT_W-1:0]] = word;
        @(negedge aclk);
    endtask

    task automatic load_layouts(input layout_load_t style);
        logic [CFG_DATA_W-1:0] word;
        for (int k = 0; k < LAYOUT_COUNT; k++) begin
            case (style)
                LOAD_ZERO: begin
                    word = '0;
                end
                LOAD_ONES: begin
                    word = '1;
                end
                LOAD_DIRECTED: begin
                    for (int n = 0; n < MAX_BUTTONS; n++) begin
                        word[KEY_W*n +: KEY_W] = 8'h04 + 8'(8 * k + n);
                    end
                    if (k == 5) word[KEY_W*3 +: KEY_W] = '0;
                    if (k == 7) word = '1;
                end
                default: begin
                    word = {$urandom, $urandom};
                    for (int n = 0; n < MAX_BUTTONS; n++) begin
                        if ($urandom_range(3) == 0) word[KEY_W*n +: KEY_W] = '0;
                    end
                end
            endcase
            cfg_write(k[CFG_ADDR_W-1:0], word);
        end
        // writes past the last layout must be dropped
        if (style == LOAD_DIRECTED || style == LOAD_RANDOM) begin
            cfg_write(LAYOUT_COUNT[CFG_ADDR_W-1:0], '1);
            cfg_write(CFG_ADDR_W'($urandom_range(LAYOUT_COUNT, 15)), {$urandom, $urandom});
            cfg_write('1, '1);
        end
        cfg_wr_en <= 1'b0;
        layout_loads++;
    endtask

    task automatic wait_drained();
        while (pending_reports.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic rand_poll(output logic [7:0] buttons, output logic sys);
        int kind;
        kind = $urandom_range(99);
        if (kind < 30)      buttons = 8'h01 << $urandom_range(7);
        else if (kind < 35) buttons = 8'h00;
        else if (kind < 40) buttons = 8'hFF;
        else if (kind < 55) buttons = 8'($urandom | $urandom);
        else                buttons = 8'($urandom);
        sys = ($urandom_range(99) < 20);
    endtask

    // sink side
    initial begin
        int holds_done;
        holds_done = 0;
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_asks != holds_done) begin
                holds_done++;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge aclk);
            end else begin
                m_tready <= ($urandom_range(99) >= sink_stall_pct);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            seen_report.slot_key      = m_tdata[47:0];
            seen_report.keys_held     = m_tdata[50:48];
            seen_report.active_layout = m_tdata[53:51];
            seen_report.mode_lamp     = m_tuser;
            if (pending_reports.size() == 0) begin
                $error("report transaction with no poll pending");
                mismatch_count++;
            end else begin
                due_report = pending_reports.pop_front();
                for (int i = 0; i < MAX_SLOTS; i++) begin
                    if (seen_report.slot_key[i] !== due_report.slot_key[i]) begin
                        $error("%s: expected %0h, got %0h", slot_name[i],
                               due_report.slot_key[i], seen_report.slot_key[i]);
                        mismatch_count++;
                    end
                end
                if (seen_report.keys_held !== due_report.keys_held) begin
                    $error("keys_held: expected %0d, got %0d",
                           due_report.keys_held, seen_report.keys_held);
                    mismatch_count++;
                end
                if (seen_report.mode_lamp !== due_report.mode_lamp) begin
                    $error("mode_lamp: expected %0b, got %0b",
                           due_report.mode_lamp, seen_report.mode_lamp);
                    mismatch_count++;
                end
                if (seen_report.active_layout !== due_report.active_layout) begin
                    $error("active_layout: expected %0d, got %0d",
                           due_report.active_layout, seen_report.active_layout);
                    mismatch_count++;
                end
                reports_checked++;
            end
        end
    end

    // watchdog on cycles with no transaction on any port
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Verification failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        logic [7:0]  btn;
        logic        sw;
        hid_report_t typed_rpt;
        aresetn        = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tuser        = 1'b0;
        cfg_wr_en      = 1'b0;
        cfg_addr       = '0;
        cfg_wdata      = '0;
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        polls_sent     = 0;
        select_polls   = 0;
        layout_loads   = 0;
        sel_layout     = '0;
        for (int k = 0; k < LAYOUT_COUNT; k++) layout_word[k] = '0;

        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed: reset defaults first, then a known layout set
        for (int i = 0; i < DIRECTED_ROWS; i++) begin
            if (i == RESET_ROWS) begin
                s_tvalid <= 1'b0;
                wait_drained();
                load_layouts(LOAD_DIRECTED);
            end
            typed_rpt               = '0;
            typed_rpt.keys_held     = directed_rows[i].held;
            typed_rpt.mode_lamp     = directed_rows[i].lamp;
            typed_rpt.active_layout = directed_rows[i].layout;
            send_poll(directed_rows[i].buttons, directed_rows[i].sys,
                      directed_rows[i].typed, typed_rpt);
        end
        s_tvalid <= 1'b0;

        for (int phase = 0; phase < PHASES; phase++) begin
            wait_drained();
            load_layouts(phase_load[phase]);
            case (phase % 4)
                0: begin
                    src_idle_pct   = 0;
                    sink_stall_pct = 0;
                    hold_asks++;
                end
                1: begin
                    src_idle_pct   = 52;
                    sink_stall_pct = 0;
                end
                2: begin
                    src_idle_pct   = 0;
                    sink_stall_pct = 52;
                end
                default: begin
                    src_idle_pct   = 36;
                    sink_stall_pct = 36;
                end
            endcase
            repeat (ITEMS_PER_PHASE) begin
                rand_poll(btn, sw);
                send_poll(btn, sw, 1'b0, '0);
            end
            s_tvalid <= 1'b0;
        end

        wait_drained();
        $display("%0d polls sent (%0d in layout selection mode), %0d reports checked",
                 polls_sent, select_polls, reports_checked);
        $display("%0d layout loads incl. all-zero, all-one and out-of-range writes",
                 layout_loads);
        if (mismatch_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
